/* rtl/integer_to_radix_digits_top_defines.svh */
// Assertion macros for the radix digit converter.
// Each macro takes a label, a property expression and a message string.
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

// Check on every clock edge outside reset.
`define I2R_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define I2R_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/i2r_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package i2r_pkg;

  // Field widths fixed by the interface
  localparam int unsigned RADIX_W = 4;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned KIND_W  = 2;

  // Accepted radix range and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

  // Dividend bits consumed per cycle by the division step
  localparam int unsigned DIV_CHUNK = 8;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DIGIT = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

/* rtl/i2r_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module i2r_ram #(
  parameter int unsigned DATA_W = 4,
  parameter int unsigned DEPTH  = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/integer_to_radix_digits_top.sv */
// Converts one signed VALUE_WIDTH-bit integer per transaction into digits of
// the base held in the radix register (2..9), most significant digit first,
// with a minus-sign result ahead of the digits of a negative value and last_o
// on the final result. Zero gives the single digit 0; a radix outside 2..9
// gives one error result. The value is divided by the radix in a shared
// long-division step that consumes 8 dividend bits per cycle, repeated over
// the dividend for each digit; remainders go onto a digit stack RAM with
// a registered read, and each digit is popped in a read state followed by an
// output state that waits for a free output slot. in_ready_o is high only
// while the converter is idle. Digits beyond STACK_DEPTH (most significant
// ones) are dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_top_defines.svh"
module integer_to_radix_digits_top #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [3:0]             cfg_radix_i,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  // output channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [3:0]                  digit_o,
  output logic                        last_o
);

  localparam int unsigned CHUNK = i2r_pkg::DIV_CHUNK;
  localparam int unsigned STEPS = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int unsigned PW    = STEPS * CHUNK;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW    = i2r_pkg::RADIX_W;
  localparam int unsigned DW    = i2r_pkg::DIGIT_W;

  i2r_pkg::state_e state_q, state_d;

  logic [RW-1:0] radix_q;
  logic [PW-1:0] mag_q, mag_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [SW-1:0] step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;

  logic               out_valid_q;
  i2r_pkg::kind_e     kind_q;
  logic [DW-1:0]      digit_q;
  logic               last_q;

  logic               emit;
  i2r_pkg::kind_e     emit_kind;
  logic [DW-1:0]      emit_digit;
  logic               emit_last;
  logic               slot_free;

  logic               ram_we, ram_re;
  logic [DW-1:0]      ram_rdata;
  logic [AW-1:0]      ram_raddr;

  logic [VALUE_WIDTH-1:0] mag_in;
  logic [PW-1:0]          mag_div;
  logic [DW-1:0]          rem_div;
  logic                   radix_bad;
  logic                   last_step;
  logic                   stack_room;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= i2r_pkg::RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  assign radix_bad = (radix_q < i2r_pkg::RADIX_MIN) || (radix_q > i2r_pkg::RADIX_MAX);

  // Unsigned magnitude of the incoming value, exact for the most negative one
  assign mag_in = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Shared division step: consume the top byte of the dividend, shift in quotient bits
  always_comb begin
    logic [DW-1:0]    r;
    logic [DW:0]      t;
    logic [CHUNK-1:0] qb;
    logic [CHUNK-1:0] top_byte;
    top_byte = mag_q[PW-1 -: CHUNK];
    r        = rem_q;
    qb       = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r, top_byte[i]};
      if (t >= {1'b0, radix_q}) begin
        qb[i] = 1'b1;
        r     = DW'(t - {1'b0, radix_q});
      end else begin
        r     = t[DW-1:0];
      end
    end
    rem_div = r;
    mag_div = (mag_q << CHUNK) | PW'(qb);
  end

  assign last_step  = (step_q == SW'(STEPS - 1));
  assign stack_room = (cnt_q < CW'(STACK_DEPTH));
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == i2r_pkg::ST_IDLE);
  assign ram_raddr  = AW'(cnt_q - CW'(1));

  // Sequencer state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2r_pkg::ST_IDLE;
      mag_q   <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mag_q   <= mag_d;
      rem_q   <= rem_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  // Next state, datapath updates and result emission
  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    rem_d      = rem_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    emit       = 1'b0;
    emit_kind  = i2r_pkg::KIND_DIGIT;
    emit_digit = '0;
    emit_last  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (state_q)
      i2r_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mag_d   = PW'(mag_in);
          neg_d   = value_i[VALUE_WIDTH-1];
          rem_d   = '0;
          step_d  = '0;
          cnt_d   = '0;
          state_d = i2r_pkg::ST_CHECK;
        end
      end
      i2r_pkg::ST_CHECK: begin
        if (radix_bad) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = i2r_pkg::KIND_ERROR;
            emit_last = 1'b1;
            state_d   = i2r_pkg::ST_IDLE;
          end
        end else if (mag_q == '0) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = i2r_pkg::KIND_DIGIT;
            emit_last = 1'b1;
            state_d   = i2r_pkg::ST_IDLE;
          end
        end else begin
          state_d = i2r_pkg::ST_DIV;
        end
      end
      i2r_pkg::ST_DIV: begin
        mag_d = mag_div;
        if (last_step) begin
          // push the remainder, drop it once the stack is full
          ram_we = stack_room;
          if (stack_room) begin
            cnt_d = cnt_q + CW'(1);
          end
          rem_d   = '0;
          step_d  = '0;
          state_d = (mag_div == '0) ? i2r_pkg::ST_SIGN : i2r_pkg::ST_DIV;
        end else begin
          rem_d  = rem_div;
          step_d = step_q + SW'(1);
        end
      end
      i2r_pkg::ST_SIGN: begin
        if (!neg_q) begin
          state_d = i2r_pkg::ST_RD;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_kind = i2r_pkg::KIND_MINUS;
          state_d   = i2r_pkg::ST_RD;
        end
      end
      i2r_pkg::ST_RD: begin
        ram_re  = 1'b1;
        cnt_d   = cnt_q - CW'(1);
        state_d = i2r_pkg::ST_OUT;
      end
      i2r_pkg::ST_OUT: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = i2r_pkg::KIND_DIGIT;
          emit_digit = ram_rdata;
          emit_last  = (cnt_q == '0);
          state_d    = (cnt_q == '0) ? i2r_pkg::ST_IDLE : i2r_pkg::ST_RD;
        end
      end
      default: begin
        state_d = i2r_pkg::ST_IDLE;
      end
    endcase
  end

  // Digit stack
  i2r_ram #(
    .DATA_W (DW),
    .DEPTH  (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_div),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= emit_kind;
      digit_q <= emit_digit;
      last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign digit_o     = digit_q;
  assign last_o      = last_q;

  // Checks
  `I2R_ASSERT_RST(a_no_result_in_reset,
    !rst_ni |=> !out_valid_o,
    "result valid during reset")
  `I2R_ASSERT(a_digit_below_radix,
    out_valid_o && (kind_o == i2r_pkg::KIND_DIGIT) |-> digit_o < radix_q,
    "digit not below radix")
  `I2R_ASSERT(a_error_only_bad_radix,
    out_valid_o && (kind_o == i2r_pkg::KIND_ERROR) |-> radix_bad && last_o && (digit_o == '0),
    "error result with valid radix")
  `I2R_ASSERT(a_minus_not_last,
    out_valid_o && (kind_o == i2r_pkg::KIND_MINUS) |-> !last_o && (digit_o == '0),
    "minus sign marked last")
  `I2R_ASSERT(a_stack_count_bound,
    cnt_q <= CW'(STACK_DEPTH),
    "digit count beyond stack depth")

endmodule
`default_nettype wire
